/* hw/rtl/idll_pkg.sv */
// Package for the indexed doubly linked list unit: payload types, codes and the microcode ROM.
package idll_pkg;

  // Default pool size, sentinels included
  localparam int unsigned CAPACITY_DEF = 64;

  // Sentinel node indices
  localparam int unsigned HEAD_NODE = 0;
  localparam int unsigned TAIL_NODE = 1;
  localparam int unsigned FIRST_FREE = 2;

  // Request kinds
  localparam logic [2:0] KIND_INS_RIGHT = 3'd0;
  localparam logic [2:0] KIND_INS_LEFT  = 3'd1;
  localparam logic [2:0] KIND_INS_HEAD  = 3'd2;
  localparam logic [2:0] KIND_INS_TAIL  = 3'd3;
  localparam logic [2:0] KIND_REMOVE    = 3'd4;
  localparam logic [2:0] KIND_CLEAR     = 3'd5;
  localparam logic [2:0] KIND_WALK      = 3'd6;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_BAD_NODE = 2'd2;

  typedef struct packed {
    logic [2:0]         kind;
    logic [5:0]         node_index;
    logic signed [31:0] value;
  } idll_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [5:0]         new_index;
    logic signed [31:0] item_value;
    logic               list_empty;
    logic               last;
  } idll_rsp_t;

  // Microcode program counter width and step addresses
  localparam int unsigned UPC_W = 5;

  localparam logic [UPC_W-1:0] UA_IR0  = 5'd0;
  localparam logic [UPC_W-1:0] UA_IR1  = 5'd1;
  localparam logic [UPC_W-1:0] UA_IL0  = 5'd2;
  localparam logic [UPC_W-1:0] UA_IL1  = 5'd3;
  localparam logic [UPC_W-1:0] UA_IL2  = 5'd4;
  localparam logic [UPC_W-1:0] UA_IL3  = 5'd5;
  localparam logic [UPC_W-1:0] UA_IH0  = 5'd6;
  localparam logic [UPC_W-1:0] UA_IH1  = 5'd7;
  localparam logic [UPC_W-1:0] UA_IT0  = 5'd8;
  localparam logic [UPC_W-1:0] UA_IT1  = 5'd9;
  localparam logic [UPC_W-1:0] UA_INW  = 5'd10;
  localparam logic [UPC_W-1:0] UA_INL  = 5'd11;
  localparam logic [UPC_W-1:0] UA_RM0  = 5'd12;
  localparam logic [UPC_W-1:0] UA_RM1  = 5'd13;
  localparam logic [UPC_W-1:0] UA_RM2  = 5'd14;
  localparam logic [UPC_W-1:0] UA_CL0  = 5'd15;
  localparam logic [UPC_W-1:0] UA_WK0  = 5'd16;
  localparam logic [UPC_W-1:0] UA_WK1  = 5'd17;
  localparam logic [UPC_W-1:0] UA_WK2  = 5'd18;
  localparam logic [UPC_W-1:0] UA_BAD  = 5'd19;

  // Read address source
  typedef enum logic [2:0] {
    RD_NONE, RD_K, RD_A, RD_HEAD, RD_TAILP, RD_NEXT
  } rd_src_e;

  // Left neighbor register source
  typedef enum logic [2:0] {
    A_KEEP, A_K, A_HEAD, A_PREV, A_TAILP
  } a_src_e;

  // Guard evaluated in a step; a failing guard answers and ends the request
  typedef enum logic [2:0] {
    CHK_NONE, CHK_RIGHT, CHK_LEFT, CHK_INS, CHK_REMOVE, CHK_EMPTY, CHK_BAD
  } chk_e;

  typedef enum logic [1:0] {
    EM_NONE, EM_OK, EM_NEW, EM_WALK
  } emit_e;

  typedef enum logic [1:0] {
    NX_SEQ, NX_JMP, NX_END, NX_WALK
  } nxt_e;

  typedef struct packed {
    rd_src_e          rd;
    a_src_e           a_ld;
    logic             b_ld;
    chk_e             chk;
    logic             wr_new;
    logic             wr_ins;
    logic             wr_rem;
    logic             clr;
    emit_e            emit;
    nxt_e             nxt;
    logic [UPC_W-1:0] tgt;
  } ucw_t;

  localparam ucw_t UCW_NOP = '{
    rd: RD_NONE, a_ld: A_KEEP, b_ld: 1'b0, chk: CHK_NONE, wr_new: 1'b0,
    wr_ins: 1'b0, wr_rem: 1'b0, clr: 1'b0, emit: EM_NONE, nxt: NX_SEQ,
    tgt: '0
  };

  // Program entry for each request kind
  function automatic logic [UPC_W-1:0] entry(logic [2:0] kind);
    logic [UPC_W-1:0] ua;
    unique case (kind)
      KIND_INS_RIGHT: ua = UA_IR0;
      KIND_INS_LEFT:  ua = UA_IL0;
      KIND_INS_HEAD:  ua = UA_IH0;
      KIND_INS_TAIL:  ua = UA_IT0;
      KIND_REMOVE:    ua = UA_RM0;
      KIND_CLEAR:     ua = UA_CL0;
      KIND_WALK:      ua = UA_WK0;
      default:        ua = UA_BAD;
    endcase
    return ua;
  endfunction

  // Microcode ROM
  function automatic ucw_t ucode(logic [UPC_W-1:0] upc);
    ucw_t cw;
    cw = UCW_NOP;
    unique case (upc)
      // insert right of node: read reference, check, take its successor
      UA_IR0: begin cw.rd = RD_K; cw.a_ld = A_K; end
      UA_IR1: begin cw.chk = CHK_RIGHT; cw.b_ld = 1'b1; cw.nxt = NX_JMP; cw.tgt = UA_INW; end
      // insert left of node: predecessor becomes the left neighbor
      UA_IL0: begin cw.rd = RD_K; end
      UA_IL1: begin cw.chk = CHK_LEFT; cw.a_ld = A_PREV; end
      UA_IL2: begin cw.rd = RD_A; end
      UA_IL3: begin cw.b_ld = 1'b1; cw.nxt = NX_JMP; cw.tgt = UA_INW; end
      // insert at head
      UA_IH0: begin cw.rd = RD_HEAD; cw.a_ld = A_HEAD; end
      UA_IH1: begin cw.chk = CHK_INS; cw.b_ld = 1'b1; cw.nxt = NX_JMP; cw.tgt = UA_INW; end
      // insert at tail
      UA_IT0: begin cw.rd = RD_TAILP; cw.a_ld = A_TAILP; end
      UA_IT1: begin cw.chk = CHK_INS; cw.b_ld = 1'b1; cw.nxt = NX_JMP; cw.tgt = UA_INW; end
      // shared insert tail: fill new node, then splice it in
      UA_INW: begin cw.wr_new = 1'b1; end
      UA_INL: begin cw.wr_ins = 1'b1; cw.emit = EM_NEW; cw.nxt = NX_END; end
      // remove
      UA_RM0: begin cw.rd = RD_K; end
      UA_RM1: begin cw.chk = CHK_REMOVE; cw.a_ld = A_PREV; cw.b_ld = 1'b1; end
      UA_RM2: begin cw.wr_rem = 1'b1; cw.emit = EM_OK; cw.nxt = NX_END; end
      // clear
      UA_CL0: begin cw.clr = 1'b1; cw.emit = EM_OK; cw.nxt = NX_END; end
      // walk: read head, then one node per step
      UA_WK0: begin cw.rd = RD_HEAD; end
      UA_WK1: begin cw.chk = CHK_EMPTY; cw.rd = RD_NEXT; end
      UA_WK2: begin cw.rd = RD_NEXT; cw.emit = EM_WALK; cw.nxt = NX_WALK; end
      // unused kind
      UA_BAD: begin cw.chk = CHK_BAD; cw.nxt = NX_END; end
      default: begin cw.chk = CHK_BAD; cw.nxt = NX_END; end
    endcase
    return cw;
  endfunction

endpackage

/* hw/rtl/indexed_doubly_linked_list_unit.sv */
// Indexed doubly linked list unit: microcoded sequencer over link and value memories.
//
// Holds a doubly linked list of up to CAPACITY-2 values in index memories,
// with node 0 as head sentinel and node 1 as tail sentinel. An accepted
// request then runs a short microprogram, one control word per cycle, with
// at most one read of the memories per step: insert right, head or tail
// 4 steps, insert left 6, remove 3, clear 1, an unused kind 1, walk 2 steps
// plus one per stored node (one result per node). A failed
// check ends the request at the step that makes it. The unit takes the next
// request in the cycle after the last step of the current one; a result
// waits in an output register, and a step that must emit holds while that
// register is full and stalled. Indices are handed out upward from 2 and
// come back only on a clear; a full pool answers status 1, a bad or
// unlinked reference answers status 2 and leaves the list unchanged.
module indexed_doubly_linked_list_unit #(
  parameter int unsigned CAPACITY = idll_pkg::CAPACITY_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  idll_pkg::idll_req_t in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output idll_pkg::idll_rsp_t out_rsp_o
);
  import idll_pkg::*;

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned FW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = (FW > 6) ? FW : 6;

  localparam logic [IW-1:0] HEAD_IX = IW'(HEAD_NODE);
  localparam logic [IW-1:0] TAIL_IX = IW'(TAIL_NODE);

  // Sequencer and request registers
  logic             busy_q;
  logic [UPC_W-1:0] upc_q;
  logic [5:0]       k_q;
  logic signed [31:0] val_q;
  logic [IW-1:0]    a_q;
  logic [IW-1:0]    b_q;

  // List state outside the memories
  logic [IW-1:0] head_next_q;
  logic [IW-1:0] tail_prev_q;
  logic [FW-1:0] next_free_q;

  // Memories and their registered read data
  logic signed [31:0] value_mem_q [CAPACITY];
  logic [IW-1:0]      next_mem_q  [CAPACITY];
  logic [IW-1:0]      prev_mem_q  [CAPACITY];
  logic               flag_mem_q  [CAPACITY];

  logic signed [31:0] value_rd_q;
  logic [IW-1:0]      next_rd_q;
  logic [IW-1:0]      prev_rd_q;
  logic               flag_rd_q;
  logic [IW-1:0]      rd_addr_q;

  // Output register
  logic      out_valid_q;
  idll_rsp_t out_q;

  // Control and datapath signals
  ucw_t          cw;
  logic [IW-1:0] n_idx;
  logic [IW-1:0] rd_next;
  logic [IW-1:0] rd_prev;
  logic [IW-1:0] rd_addr;
  logic          rd_en;
  logic          k_linked;
  logic          pool_full;
  logic          walk_last;
  logic          fail;
  logic [1:0]    fail_status;
  logic          fail_empty;
  logic          emit_v;
  logic          out_free;
  logic          adv;
  logic          step_go;
  logic          done;
  idll_rsp_t     rsp_d;
  logic          in_acc;

  assign cw       = ucode(upc_q);
  assign n_idx    = next_free_q[IW-1:0];
  assign rd_next  = (rd_addr_q == HEAD_IX) ? head_next_q : next_rd_q;
  assign rd_prev  = (rd_addr_q == TAIL_IX) ? tail_prev_q : prev_rd_q;
  assign k_linked = (k_q >= 6'(FIRST_FREE)) && (CW'(k_q) < CW'(next_free_q)) && flag_rd_q;
  assign pool_full = (next_free_q == FW'(CAPACITY));
  assign walk_last = (rd_next == TAIL_IX);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign in_acc    = in_valid_i && !busy_q;

  // Evaluate the step guard
  always_comb begin
    fail        = 1'b0;
    fail_status = ST_OK;
    fail_empty  = 1'b0;
    unique case (cw.chk)
      CHK_NONE: ;
      CHK_RIGHT: begin
        if (!(k_q == 6'(HEAD_NODE) || k_linked)) begin
          fail = 1'b1;
          fail_status = ST_BAD_NODE;
        end else if (pool_full) begin
          fail = 1'b1;
          fail_status = ST_FULL;
        end
      end
      CHK_LEFT: begin
        if (!(k_q == 6'(TAIL_NODE) || k_linked)) begin
          fail = 1'b1;
          fail_status = ST_BAD_NODE;
        end else if (pool_full) begin
          fail = 1'b1;
          fail_status = ST_FULL;
        end
      end
      CHK_INS: begin
        fail = pool_full;
        fail_status = ST_FULL;
      end
      CHK_REMOVE: begin
        fail = !k_linked;
        fail_status = ST_BAD_NODE;
      end
      CHK_EMPTY: begin
        fail = walk_last;
        fail_empty = 1'b1;
      end
      CHK_BAD: begin
        fail = 1'b1;
        fail_status = ST_BAD_NODE;
      end
      default: ;
    endcase
  end

  // Step advance and request completion
  always_comb begin
    emit_v  = (cw.emit != EM_NONE) || fail;
    adv     = busy_q && (!emit_v || out_free);
    step_go = adv && !fail;
    done    = fail || (cw.nxt == NX_END) || ((cw.nxt == NX_WALK) && walk_last);
  end

  // Build the result
  always_comb begin
    rsp_d = '0;
    if (fail) begin
      rsp_d.status     = fail_status;
      rsp_d.list_empty = fail_empty;
      rsp_d.last       = 1'b1;
    end else begin
      unique case (cw.emit)
        EM_NONE: ;
        EM_OK:   rsp_d.last = 1'b1;
        EM_NEW: begin
          rsp_d.new_index = 6'(n_idx);
          rsp_d.last      = 1'b1;
        end
        EM_WALK: begin
          rsp_d.item_value = value_rd_q;
          rsp_d.last       = walk_last;
        end
        default: ;
      endcase
    end
  end

  // Select the read address
  always_comb begin
    rd_en   = step_go && (cw.rd != RD_NONE);
    rd_addr = HEAD_IX;
    unique case (cw.rd)
      RD_NONE:  rd_addr = HEAD_IX;
      RD_K:     rd_addr = IW'(k_q);
      RD_A:     rd_addr = a_q;
      RD_HEAD:  rd_addr = HEAD_IX;
      RD_TAILP: rd_addr = tail_prev_q;
      RD_NEXT:  rd_addr = rd_next;
      default:  rd_addr = HEAD_IX;
    endcase
  end

  // Sequencer: accept a request, step the program, drop busy at the end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      upc_q  <= UA_BAD;
    end else if (in_acc) begin
      busy_q <= 1'b1;
      upc_q  <= entry(in_req_i.kind);
    end else if (adv) begin
      if (done) begin
        busy_q <= 1'b0;
      end else if (cw.nxt == NX_JMP) begin
        upc_q <= cw.tgt;
      end else if (cw.nxt == NX_SEQ) begin
        upc_q <= upc_q + UPC_W'(1);
      end
    end
  end

  // Hold the request fields
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      k_q    <= in_req_i.node_index;
      val_q  <= in_req_i.value;
    end
  end

  // Load the neighbor registers
  always_ff @(posedge clk_i) begin
    if (step_go) begin
      unique case (cw.a_ld)
        A_KEEP:  ;
        A_K:     a_q <= IW'(k_q);
        A_HEAD:  a_q <= HEAD_IX;
        A_PREV:  a_q <= rd_prev;
        A_TAILP: a_q <= tail_prev_q;
        default: ;
      endcase
      if (cw.b_ld) begin
        b_q <= rd_next;
      end
    end
  end

  // Sentinel links and allocation pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_next_q <= TAIL_IX;
      tail_prev_q <= HEAD_IX;
      next_free_q <= FW'(FIRST_FREE);
    end else if (step_go) begin
      if (cw.clr) begin
        head_next_q <= TAIL_IX;
        tail_prev_q <= HEAD_IX;
        next_free_q <= FW'(FIRST_FREE);
      end
      if (cw.wr_ins) begin
        if (a_q == HEAD_IX) begin
          head_next_q <= n_idx;
        end
        if (b_q == TAIL_IX) begin
          tail_prev_q <= n_idx;
        end
        next_free_q <= next_free_q + FW'(1);
      end
      if (cw.wr_rem) begin
        if (a_q == HEAD_IX) begin
          head_next_q <= b_q;
        end
        if (b_q == TAIL_IX) begin
          tail_prev_q <= a_q;
        end
      end
    end
  end

  // Registered reads of all memories at one address
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      value_rd_q <= value_mem_q[rd_addr];
      next_rd_q  <= next_mem_q[rd_addr];
      prev_rd_q  <= prev_mem_q[rd_addr];
      flag_rd_q  <= flag_mem_q[rd_addr];
      rd_addr_q  <= rd_addr;
    end
  end

  // Value memory: written when a node is filled
  always_ff @(posedge clk_i) begin
    if (step_go && cw.wr_new) begin
      value_mem_q[n_idx] <= val_q;
    end
  end

  // Next-link memory
  always_ff @(posedge clk_i) begin
    if (step_go) begin
      if (cw.wr_new) begin
        next_mem_q[n_idx] <= b_q;
      end else if (cw.wr_ins && a_q != HEAD_IX) begin
        next_mem_q[a_q] <= n_idx;
      end else if (cw.wr_rem && a_q != HEAD_IX) begin
        next_mem_q[a_q] <= b_q;
      end
    end
  end

  // Prev-link memory
  always_ff @(posedge clk_i) begin
    if (step_go) begin
      if (cw.wr_new) begin
        prev_mem_q[n_idx] <= a_q;
      end else if (cw.wr_ins && b_q != TAIL_IX) begin
        prev_mem_q[b_q] <= n_idx;
      end else if (cw.wr_rem && b_q != TAIL_IX) begin
        prev_mem_q[b_q] <= a_q;
      end
    end
  end

  // Linked-flag memory; entries at or above next_free are ignored
  always_ff @(posedge clk_i) begin
    if (step_go) begin
      if (cw.wr_new) begin
        flag_mem_q[n_idx] <= 1'b1;
      end else if (cw.wr_rem) begin
        flag_mem_q[IW'(k_q)] <= 1'b0;
      end
    end
  end

  // Output register: load on emit, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && emit_v) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit_v) begin
      out_q <= rsp_d;
    end
  end

  assign in_stall_o  = busy_q;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule
